FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of the find-and-replace core.
// SFR_ASSERT expects signals named clk and rst_n in the scope where it is used, SFR_ASSERT_RST only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is applied.
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is applied.
`define SFR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/sfr_pkg.sv
// Shared types and constants for the streaming find-and-replace core.
// No dependencies; all module files of the core but the checker refer to it by scoped names.
package sfr_pkg;

  // Largest supported pattern length and the default for the top level.
  localparam int MAX_PATTERN_DEF = 8;

  // Bytes carried by one job, and the width of a byte count 0..JOB_BYTES.
  localparam int JOB_BYTES = 8;
  localparam int LEN_W     = 4;

  // Configuration port geometry: four 64-bit registers at byte address 8*i.
  localparam int CFG_DATA_W = 64;
  localparam int ADDR_W     = 5;

  // Depth of the job queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;

  // End-of-line byte, which closes the line like the flush input.
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_PATTERN_BYTES,
    REG_PATTERN_LENGTH,
    REG_REPLACEMENT_BYTES,
    REG_REPLACEMENT_LENGTH
  } reg_idx_t;

  // Effective configuration seen by the front end, lengths already clamped.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern;
    logic [LEN_W-1:0]      plen;
    logic [CFG_DATA_W-1:0] repl;
    logic [LEN_W-1:0]      rlen;
  } cfg_t;

  // One job: up to eight output bytes, byte 0 in the low eight bits.
  typedef struct packed {
    logic [8*JOB_BYTES-1:0] data;
    logic [LEN_W-1:0]       len;
  } job_t;

endpackage

FILE: hdl/sfr_regs.sv
// Configuration registers of the find-and-replace core behind an APB-style port.
// Depends on sfr_pkg for the register map, widths and the cfg_t type.
module sfr_regs #(
  parameter int MaxPattern = sfr_pkg::MAX_PATTERN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0]      paddr,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sfr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output sfr_pkg::cfg_t                   cfg
);

  logic [sfr_pkg::CFG_DATA_W-1:0] pat_r, pat_nxt;
  logic [sfr_pkg::LEN_W-1:0]      plen_r, plen_nxt;
  logic [sfr_pkg::CFG_DATA_W-1:0] repl_r, repl_nxt;
  logic [sfr_pkg::LEN_W-1:0]      rlen_r, rlen_nxt;
  logic                           wr_en;
  sfr_pkg::reg_idx_t              idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = sfr_pkg::reg_idx_t'(paddr[sfr_pkg::ADDR_W-1:3]);

  // Register write decode; a transfer updates the addressed register only.
  always_comb begin
    pat_nxt  = pat_r;
    plen_nxt = plen_r;
    repl_nxt = repl_r;
    rlen_nxt = rlen_r;
    if (wr_en) begin
      unique case (idx)
        sfr_pkg::REG_PATTERN_BYTES:      pat_nxt  = pwdata;
        sfr_pkg::REG_PATTERN_LENGTH:     plen_nxt = pwdata[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:  repl_nxt = pwdata;
        sfr_pkg::REG_REPLACEMENT_LENGTH: rlen_nxt = pwdata[sfr_pkg::LEN_W-1:0];
      endcase
    end
  end

  // Read mux returns the raw stored values.
  always_comb begin
    unique case (idx)
      sfr_pkg::REG_PATTERN_BYTES:      prdata = pat_r;
      sfr_pkg::REG_PATTERN_LENGTH:     prdata = sfr_pkg::CFG_DATA_W'(plen_r);
      sfr_pkg::REG_REPLACEMENT_BYTES:  prdata = repl_r;
      sfr_pkg::REG_REPLACEMENT_LENGTH: prdata = sfr_pkg::CFG_DATA_W'(rlen_r);
    endcase
  end

  // Effective lengths: an empty pattern counts as one byte, and both
  // lengths are clamped to what the datapath holds.
  always_comb begin
    cfg.pattern = pat_r;
    cfg.repl    = repl_r;
    if (plen_r == '0) begin
      cfg.plen = sfr_pkg::LEN_W'(1);
    end else if (plen_r > sfr_pkg::LEN_W'(MaxPattern)) begin
      cfg.plen = sfr_pkg::LEN_W'(MaxPattern);
    end else begin
      cfg.plen = plen_r;
    end
    if (rlen_r > sfr_pkg::LEN_W'(sfr_pkg::JOB_BYTES)) begin
      cfg.rlen = sfr_pkg::LEN_W'(sfr_pkg::JOB_BYTES);
    end else begin
      cfg.rlen = rlen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      plen_r <= sfr_pkg::LEN_W'(1);
      repl_r <= '0;
      rlen_r <= '0;
    end else begin
      pat_r  <= pat_nxt;
      plen_r <= plen_nxt;
      repl_r <= repl_nxt;
      rlen_r <= rlen_nxt;
    end
  end

endmodule

FILE: hdl/sfr_front.sv
// Front end of the find-and-replace core: hold window, match and prefix checks.
// Each accepted byte becomes at most one job of output bytes. Depends on sfr_pkg.
module sfr_front #(
  parameter int MaxPattern = sfr_pkg::MAX_PATTERN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    in_byte,
  input  logic          in_flush,
  input  sfr_pkg::cfg_t cfg,
  input  logic          q_full,
  output logic          q_push,
  output sfr_pkg::job_t q_job
);

  localparam int CntW = $clog2(MaxPattern + 1);
  localparam int LenW = sfr_pkg::LEN_W;

  logic [7:0]      win_r [MaxPattern];
  logic [7:0]      win_nxt [MaxPattern];
  logic [CntW-1:0] cnt_r, cnt_nxt;

  logic [7:0]        ww [MaxPattern];
  logic [7:0]        win_shift [MaxPattern];
  logic [CntW-1:0]   n;
  logic [CntW-1:0]   s_sel;
  logic [MaxPattern:0] keep_ok;
  logic              line_end;
  logic              full_hit;
  logic              accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Append the new byte and test for a whole-pattern match.
  always_comb begin
    n        = cnt_r + CntW'(1);
    line_end = in_flush || (in_byte == sfr_pkg::NEWLINE_BYTE);
    for (int i = 0; i < MaxPattern; i++) begin
      ww[i] = (CntW'(i) == cnt_r) ? in_byte : win_r[i];
    end
    full_hit = (LenW'(n) == cfg.plen);
    for (int i = 0; i < MaxPattern; i++) begin
      if (LenW'(i) < cfg.plen && ww[i] != cfg.pattern[8*i +: 8]) begin
        full_hit = 1'b0;
      end
    end
  end

  // For every shift amount, check in parallel whether the remaining bytes are empty or a
  // proper prefix of the pattern; take the smallest shift, or shift out all at line end.
  always_comb begin
    for (int s = 0; s <= MaxPattern; s++) begin
      keep_ok[s] = (CntW'(s) == n) ||
                   (CntW'(s) < n && LenW'(n - CntW'(s)) < cfg.plen);
      for (int j = 0; j < MaxPattern - s; j++) begin
        if (CntW'(j) < n - CntW'(s) && ww[s+j] != cfg.pattern[8*j +: 8]) begin
          keep_ok[s] = 1'b0;
        end
      end
    end
    s_sel = n;
    for (int s = MaxPattern; s >= 0; s--) begin
      if (keep_ok[s]) begin
        s_sel = CntW'(s);
      end
    end
    if (line_end) begin
      s_sel = n;
    end
  end

  // Shift the window down by the selected amount.
  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      win_shift[i] = ww[i];
      for (int k = 1; k < MaxPattern - i; k++) begin
        if (CntW'(k) == s_sel) begin
          win_shift[i] = ww[i+k];
        end
      end
    end
  end

  // Build the job and the next window state.
  always_comb begin
    q_job.data = '0;
    if (full_hit) begin
      q_job.data = cfg.repl;
      q_job.len  = cfg.rlen;
      cnt_nxt    = '0;
      win_nxt    = win_shift;
    end else begin
      for (int i = 0; i < MaxPattern; i++) begin
        q_job.data[8*i +: 8] = ww[i];
      end
      q_job.len = LenW'(s_sel);
      cnt_nxt   = n - s_sel;
      win_nxt   = win_shift;
    end
    q_push = accept && (q_job.len != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Window bytes beyond the count are never read, so they need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

FILE: hdl/sfr_queue.sv
// Short job queue between the front and back ends of the find-and-replace core.
// Depends on sfr_pkg for the job type and the queue depth.
module sfr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  sfr_pkg::job_t wr_job,
  output logic          q_full,
  input  logic          rd_en,
  output logic          rd_valid,
  output sfr_pkg::job_t rd_job
);

  localparam int PtrW = (sfr_pkg::QUEUE_DEPTH > 1) ? $clog2(sfr_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(sfr_pkg::QUEUE_DEPTH + 1);

  sfr_pkg::job_t   slot_r [sfr_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign q_full   = (cnt_r == CntW'(sfr_pkg::QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = slot_r[rd_ptr_r];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  // Pointer and fill count update for each transfer on either side.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(sfr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(sfr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

FILE: hdl/sfr_back.sv
// Back end of the find-and-replace core: drains jobs one byte per cycle while results are taken.
// Holds the current job and the output register. Depends on sfr_pkg.
module sfr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  sfr_pkg::job_t q_job,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          out_last_of_run
);

  logic [8*sfr_pkg::JOB_BYTES-1:0] data_r, data_nxt;
  logic [sfr_pkg::LEN_W-1:0]       left_r, left_nxt;
  logic                            ovld_r, ovld_nxt;
  logic [7:0]                      obyte_r, obyte_nxt;
  logic                            olast_r, olast_nxt;
  logic                            out_ready;
  logic                            emit;

  assign out_ready = !ovld_r || pop;
  assign emit      = out_ready && (left_r != '0);
  assign q_pop     = q_valid &&
                     ((left_r == '0) || (left_r == sfr_pkg::LEN_W'(1) && emit));

  assign empty           = !ovld_r;
  assign out_byte        = obyte_r;
  assign out_last_of_run = olast_r;

  // Current job: load the next one when this one is done or ends now.
  always_comb begin
    data_nxt = data_r;
    left_nxt = left_r;
    if (q_pop) begin
      data_nxt = q_job.data;
      left_nxt = q_job.len;
    end else if (emit) begin
      data_nxt = data_r >> 8;
      left_nxt = left_r - sfr_pkg::LEN_W'(1);
    end
  end

  // Output register: refilled from the job, cleared by a transfer out.
  always_comb begin
    ovld_nxt  = ovld_r;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    if (emit) begin
      ovld_nxt  = 1'b1;
      obyte_nxt = data_r[7:0];
      olast_nxt = (left_r == sfr_pkg::LEN_W'(1));
    end else if (pop) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      left_r <= left_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

endmodule

FILE: hdl/stream_find_replace_core.sv
// Data path: a result passes through the job queue, the current-job register of the back end
// and then the output register before it shows on the output ports.
// Throughput: one input byte per cycle while the two-entry job queue has room; the back
// end delivers one result byte per cycle while results are taken, so long jobs can hold up the input.
// Reset: synchronous, active low; empties the hold window, job queue and output register
// and returns the configuration registers to their defaults.
module stream_find_replace_core #(
  parameter int MaxPattern = sfr_pkg::MAX_PATTERN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     in_byte,
  input  logic                           in_flush,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte,
  output logic                           out_last_of_run,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0]     paddr,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sfr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  sfr_pkg::cfg_t cfg;
  sfr_pkg::job_t wr_job;
  sfr_pkg::job_t rd_job;
  logic          q_full;
  logic          q_push;
  logic          q_valid;
  logic          q_pop;

  // Configuration registers.
  sfr_regs #(
    .MaxPattern (MaxPattern)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front end turns each input byte into at most one job.
  sfr_front #(
    .MaxPattern (MaxPattern)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .in_flush (in_flush),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (wr_job)
  );

  // Job queue decouples the two ends.
  sfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_job   (wr_job),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_job   (rd_job)
  );

  // Back end emits the job bytes as results.
  sfr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_job           (rd_job),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: hdl/sfr_checker.sv
// Port-level checks for the find-and-replace core, attached by a bind statement.
// Depends on assert_macros.svh and on the port names of stream_find_replace_core.
`include "assert_macros.svh"

module sfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_last_of_run
);

  // Reset leaves no result waiting and room for input.
  `SFR_ASSERT_RST(a_reset_empty, !rst_n |=> empty, "result present after reset")
  `SFR_ASSERT_RST(a_reset_not_full, !rst_n |=> !full, "queue full after reset")

  // A waiting result that is not taken stays as it is.
  `SFR_ASSERT(a_hold_result, !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_last_of_run), "waiting result changed")

  // A run continues without a gap once a byte that is not its last is taken.
  `SFR_ASSERT(a_run_no_gap, pop && !empty && !out_last_of_run |=> !empty, "gap inside a run of results")

endmodule

bind stream_find_replace_core sfr_checker u_sfr_checker (.*);
